// ----- src/max_heap_priority_queue_macros.svh -----
// assertion macros used by the heap priority queue checker
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define MHPQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define MHPQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mhpq_pkg.sv -----
// shared types, constants and codes for the heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int CAPACITY    = 63;
    localparam int ADDR_W      = $clog2(CAPACITY + 1);
    localparam int CNT_W       = ADDR_W;
    localparam int KEY_W       = 32;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [ADDR_W-1:0] ROOT_IDX = ADDR_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_READ,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_READ,
        S_DN_PICK,
        S_DN_SWAP,
        S_PLACE,
        S_FINISH
    } state_t;

    // memory request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } mem_req_t;

    // one finished result
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic [KEY_W-1:0]  top;
    } result_t;

endpackage

// ----- src/mhpq_ram.sv -----
// heap key storage: one write port, two registered read ports
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read ports
    always_ff @(posedge aclk) begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- src/mhpq_cmp.sv -----
// shared signed key comparator
`timescale 1ns / 1ps

module mhpq_cmp import mhpq_pkg::*; (
    input  logic [KEY_W-1:0] x,
    input  logic [KEY_W-1:0] y,
    output logic             gt
);

    // strict signed greater-than
    assign gt = $signed(x) > $signed(y);

endmodule

// ----- src/mhpq_seq.sv -----
// sift sequencer: walks the tree one level at a time over the key memory
`timescale 1ns / 1ps

module mhpq_seq import mhpq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_cmd,
    input  logic [KEY_W-1:0] in_key,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res,
    output mem_req_t         mem_req,
    input  logic [KEY_W-1:0] rd_a,
    input  logic [KEY_W-1:0] rd_b,
    output logic [KEY_W-1:0] cmp_x,
    output logic [KEY_W-1:0] cmp_y,
    input  logic             cmp_gt
);

    state_t            state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0] idx_reg,    idx_next;
    logic [ADDR_W-1:0] pick_reg,   pick_next;
    logic [KEY_W-1:0]  key_reg,    key_next;
    logic [KEY_W-1:0]  child_reg,  child_next;
    logic [KEY_W-1:0]  top_reg,    top_next;

    logic [ADDR_W:0]   left_w;
    logic [ADDR_W:0]   right_w;
    logic [ADDR_W:0]   count_w;
    logic [ADDR_W-1:0] parent;

    assign left_w  = {idx_reg, 1'b0};
    assign right_w = {idx_reg, 1'b1};
    assign count_w = {1'b0, count_reg};
    assign parent  = idx_reg >> 1;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        idx_reg    <= idx_next;
        pick_reg   <= pick_next;
        key_reg    <= key_next;
        child_reg  <= child_next;
        top_reg    <= top_next;
    end

    // next state and datapath control
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        pick_next   = pick_reg;
        key_next    = key_reg;
        child_next  = child_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        mem_req.we      = 1'b0;
        mem_req.waddr   = idx_reg;
        mem_req.wdata   = key_reg;
        mem_req.raddr_a = count_reg;
        mem_req.raddr_b = right_w[ADDR_W-1:0];

        cmp_x = key_reg;
        cmp_y = rd_a;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                // last entry is read ahead for a pop
                mem_req.raddr_a = count_reg;
                if (in_valid) begin
                    status_next = ST_OK;
                    if (in_cmd == CMD_PUSH) begin
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end else begin
                            count_next = count_reg + 1'b1;
                            idx_next   = count_reg + 1'b1;
                            key_next   = in_key;
                            state_next = (count_reg == '0) ? S_PLACE : S_UP_READ;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end else begin
                            count_next = count_reg - 1'b1;
                            state_next = S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_READ: begin
                mem_req.raddr_a = parent;
                state_next      = S_UP_CMP;
            end
            S_UP_CMP: begin
                cmp_x      = key_reg;
                cmp_y      = rd_a;
                mem_req.we = 1'b1;
                if (cmp_gt) begin
                    // parent moves down into the hole
                    mem_req.wdata = rd_a;
                    idx_next      = parent;
                    state_next    = (parent == ROOT_IDX) ? S_PLACE : S_UP_READ;
                end else begin
                    mem_req.wdata = key_reg;
                    state_next    = S_FINISH;
                end
            end
            S_DN_LAST: begin
                key_next   = rd_a;
                idx_next   = ROOT_IDX;
                state_next = S_DN_READ;
            end
            S_DN_READ: begin
                if (left_w > count_w) begin
                    state_next = S_PLACE;
                end else begin
                    mem_req.raddr_a = left_w[ADDR_W-1:0];
                    mem_req.raddr_b = right_w[ADDR_W-1:0];
                    state_next      = S_DN_PICK;
                end
            end
            S_DN_PICK: begin
                // larger valid child, left on a tie
                cmp_x = rd_b;
                cmp_y = rd_a;
                if (right_w <= count_w && cmp_gt) begin
                    child_next = rd_b;
                    pick_next  = right_w[ADDR_W-1:0];
                end else begin
                    child_next = rd_a;
                    pick_next  = left_w[ADDR_W-1:0];
                end
                state_next = S_DN_SWAP;
            end
            S_DN_SWAP: begin
                cmp_x = child_reg;
                cmp_y = key_reg;
                if (cmp_gt) begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = child_reg;
                    idx_next      = pick_reg;
                    state_next    = S_DN_READ;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = key_reg;
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // root shadow follows every write to the root slot
    always_comb begin
        top_next = top_reg;
        if (mem_req.we && mem_req.waddr == ROOT_IDX) begin
            top_next = mem_req.wdata;
        end
    end

    assign res.top    = (count_reg != '0) ? top_reg : '0;
    assign res.count  = count_reg;
    assign res.status = status_reg;

endmodule

// ----- src/max_heap_priority_queue.sv -----
// Binary max-heap priority queue over signed 32-bit keys, 63 entries.
//
// s_ channel: one command per transfer. s_tdata[0] is the command (push or
// pop), s_tdata[32:1] the key for a push. s_tready is high only while the
// block is idle, so one command is in work at a time.
// m_ channel: exactly one result per command: the maximum after the
// operation (zero when empty), the entry count and a status (ok, pop on
// empty, push on full). A push on a full heap is dropped.
// A push reads and compares one parent per level as the key climbs; a pop
// takes the last entry as its key and, per level it descends, reads both
// children, picks the larger and compares it with the key. A push on full or
// a pop on empty goes straight to the result. s_tready rises on the same edge
// as m_tvalid. The single key memory and the one shared comparator serve
// each tree level in turn.
// The result sits in an output register; the sequencer holds in its finish
// state while that register is still full and m_tready is low.
// Reset (aresetn low, synchronous) empties the heap and drops any result
// waiting; the key memory itself is not cleared.
`timescale 1ns / 1ps

module max_heap_priority_queue import mhpq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // command[0], key_value[32:1], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // top_value[31:0], entry_count[37:32],
                                              // status[39:38]
);

    mem_req_t         mem_req;
    logic [KEY_W-1:0] rd_a;
    logic [KEY_W-1:0] rd_b;
    logic [KEY_W-1:0] cmp_x;
    logic [KEY_W-1:0] cmp_y;
    logic             cmp_gt;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    logic             m_tvalid_reg, m_tvalid_next;
    result_t          m_res_reg,    m_res_next;

    mhpq_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (KEY_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (mem_req.we),
        .waddr   (mem_req.waddr),
        .wdata   (mem_req.wdata),
        .raddr_a (mem_req.raddr_a),
        .raddr_b (mem_req.raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    mhpq_cmp u_cmp (
        .x  (cmp_x),
        .y  (cmp_y),
        .gt (cmp_gt)
    );

    mhpq_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[0]),
        .in_key    (s_tdata[KEY_W:1]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .cmp_x     (cmp_x),
        .cmp_y     (cmp_y),
        .cmp_gt    (cmp_gt)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_res_reg);

endmodule

// ----- src/mhpq_checker.sv -----
// port-level checker for the heap priority queue, bound to the top level
`timescale 1ns / 1ps

`include "max_heap_priority_queue_macros.svh"

module mhpq_checker import mhpq_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [KEY_W-1:0]  o_top;
    logic [CNT_W-1:0]  o_count;
    logic [STAT_W-1:0] o_status;

    logic              m_stall;
    logic              s_xfer;
    logic              st_full;
    logic              st_empty;
    logic              rep_none;
    logic              cnt_cap;
    logic              cnt_zero;
    logic              top_zero;

    assign o_top    = m_tdata[KEY_W-1:0];
    assign o_count  = m_tdata[KEY_W+CNT_W-1:KEY_W];
    assign o_status = m_tdata[KEY_W+CNT_W+STAT_W-1:KEY_W+CNT_W];

    // handshake and result terms
    assign m_stall  = m_tvalid && !m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign st_full  = m_tvalid && (o_status == ST_FULL);
    assign st_empty = m_tvalid && (o_status == ST_EMPTY);
    assign rep_none = m_tvalid && (o_count == '0);
    assign cnt_cap  = (o_count == CNT_W'(CAPACITY));
    assign cnt_zero = (o_count == '0);
    assign top_zero = (o_top == '0);

    // a stalled result holds
    `MHPQ_ASSERT_NXT(a_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata), "result moved")

    // one command in work at a time
    `MHPQ_ASSERT_NXT(a_one_cmd, aclk, aresetn, s_xfer, !s_tready, "command taken while busy")

    // full status only with a full heap
    `MHPQ_ASSERT_IMP(a_full, aclk, aresetn, st_full, cnt_cap, "full status below capacity")

    // empty status reports an empty heap
    `MHPQ_ASSERT_IMP(a_empty, aclk, aresetn, st_empty, cnt_zero && top_zero, "empty with data")

    // empty heap reports zero maximum
    `MHPQ_ASSERT_IMP(a_zero_top, aclk, aresetn, rep_none, top_zero, "nonzero top when empty")

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
